// File: rtl/rfb_pkg.sv
// ----------------------------------------------------------------------------
// rfb_pkg - shared types and constants for the request frame builder
// Job descriptor passed from the front end to the back end, step codes of the
// back-end sequencer and the bytewise Modbus CRC-16 update.
// ----------------------------------------------------------------------------
package rfb_pkg;

	localparam logic [15:0] CRC_INIT    = 16'hFFFF;
	localparam logic [15:0] CRC_POLY    = 16'hA001;
	localparam logic [7:0]  HEADER_INIT = 8'h3E;

	// input command codes
	localparam logic CMD_START   = 1'b0;
	localparam logic CMD_PAYLOAD = 1'b1;

	typedef enum logic {
		JOB_START = 1'b0,
		JOB_DATA  = 1'b1
	} job_kind_t;

	// a start job carries packet_seq, device_addr, command_code, payload_len in
	// f0..f3; a data job carries its byte in f3
	typedef struct packed {
		job_kind_t   kind;
		logic        close;
		logic [7:0]  f0;
		logic [7:0]  f1;
		logic [7:0]  f2;
		logic [7:0]  f3;
	} job_t;

	typedef logic [2:0] step_t;

	localparam step_t STEP_HEADER = 3'd0;
	localparam step_t STEP_SEQ = 3'd1;
	localparam step_t STEP_ADDR = 3'd2;
	localparam step_t STEP_CODE = 3'd3;
	localparam step_t STEP_LAST_FIELD = 3'd4;
	localparam step_t STEP_CRC_LO = 3'd5;
	localparam step_t STEP_CRC_HI = 3'd6;

	function automatic logic [15:0] crc_fold(input logic [15:0] crc_in, input logic [7:0] b);
		logic [15:0] c;
		c = crc_in ^ {8'h00, b};
		for (int i = 0; i < 8; i++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

// File: rtl/rfb_queue.sv
// ----------------------------------------------------------------------------
// rfb_queue - job queue between front end and back end
// Small register FIFO of job descriptors, head visible without a read cycle.
// ----------------------------------------------------------------------------
module rfb_queue import rfb_pkg::*; #(
	parameter int DEPTH = 4
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_job,
	output logic full,
	input  logic pop,
	output job_t head_job,
	output logic empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	job_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full     = (count_q == CNT_W'(DEPTH));
	assign empty    = (count_q == '0);
	assign head_job = mem_q[rd_ptr_q];

	function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(p + 1'b1);
	endfunction

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_next(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_next(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= CNT_W'(count_q + 1'b1);
			end else if (pop && !push) begin
				count_q <= CNT_W'(count_q - 1'b1);
			end
		end
	end

endmodule

// File: rtl/rfb_front.sv
// ----------------------------------------------------------------------------
// rfb_front - input acceptance and classification
// Tracks the open frame and payload count, turns each transaction into a
// job for the back end or drops stray payload bytes.
// ----------------------------------------------------------------------------
module rfb_front import rfb_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       cmd,
	input  logic [7:0] packet_seq,
	input  logic [7:0] device_addr,
	input  logic [7:0] command_code,
	input  logic [7:0] payload_len,
	input  logic [7:0] data_byte,
	output logic       push,
	output job_t       push_job,
	input  logic       full
);

	logic       frame_open_q;
	logic [7:0] bytes_left_q;
	logic       accept;

	assign in_ready = !full;
	assign accept   = in_valid && in_ready;

	// drop payload bytes that arrive with no frame open
	assign push = accept && ((cmd == CMD_START) || frame_open_q);

	always_comb begin
		push_job = '0;
		if (cmd == CMD_START) begin
			push_job.kind  = JOB_START;
			push_job.close = (payload_len == 8'd0);
			push_job.f0    = packet_seq;
			push_job.f1    = device_addr;
			push_job.f2    = command_code;
			push_job.f3    = payload_len;
		end else begin
			push_job.kind  = JOB_DATA;
			push_job.close = (bytes_left_q == 8'd1);
			push_job.f3    = data_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_open_q <= 1'b0;
			bytes_left_q <= '0;
		end else if (push) begin
			if (cmd == CMD_START) begin
				frame_open_q <= (payload_len != 8'd0);
				bytes_left_q <= payload_len;
			end else begin
				frame_open_q <= (bytes_left_q != 8'd1);
				bytes_left_q <= bytes_left_q - 8'd1;
			end
		end
	end

	a_open_has_count: assert property (@(posedge clk) disable iff (!arst_n)
		frame_open_q |-> bytes_left_q != 8'd0)
		else $error("frame open with no payload bytes left");

	a_closed_no_count: assert property (@(posedge clk) disable iff (!arst_n)
		!frame_open_q |-> bytes_left_q == 8'd0)
		else $error("payload count left over with no frame open");

endmodule

// File: rtl/rfb_back.sv
// ----------------------------------------------------------------------------
// rfb_back - frame byte sequencer with CRC
// Walks each job byte by byte, folds emitted bytes into the CRC, appends the
// CRC on frame close and drives the output register.
// ----------------------------------------------------------------------------
module rfb_back import rfb_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [7:0] header_byte,
	input  job_t       head_job,
	input  logic       empty,
	output logic       pop,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       frame_last
);

	logic        busy_q;
	step_t       step_q;
	logic [15:0] crc_q;
	logic        out_valid_q;
	logic [7:0]  out_byte_q;
	logic        frame_last_q;

	logic        emit;
	logic        job_done;
	step_t       cur_step;
	logic [7:0]  cur_byte;
	logic [15:0] crc_base;

	assign emit = !empty && (!out_valid_q || out_ready);

	always_comb begin
		if (busy_q) begin
			cur_step = step_q;
		end else if (head_job.kind == JOB_START) begin
			cur_step = STEP_HEADER;
		end else begin
			cur_step = STEP_LAST_FIELD;
		end
	end

	always_comb begin
		case (cur_step)
			STEP_HEADER:     cur_byte = header_byte;
			STEP_SEQ:        cur_byte = head_job.f0;
			STEP_ADDR:       cur_byte = head_job.f1;
			STEP_CODE:       cur_byte = head_job.f2;
			STEP_LAST_FIELD: cur_byte = head_job.f3;
			STEP_CRC_LO:     cur_byte = crc_q[7:0];
			STEP_CRC_HI:     cur_byte = crc_q[15:8];
			default:         cur_byte = 8'h00;
		endcase
	end

	// a start job restarts the CRC, abandoning any open frame
	assign crc_base = (cur_step == STEP_HEADER) ? CRC_INIT : crc_q;

	assign job_done = (cur_step == STEP_CRC_HI) ||
		((cur_step == STEP_LAST_FIELD) && !head_job.close);
	assign pop = emit && job_done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			step_q      <= STEP_HEADER;
			crc_q       <= CRC_INIT;
			out_valid_q <= 1'b0;
		end else begin
			if (emit) begin
				out_valid_q <= 1'b1;
				busy_q      <= !job_done;
				step_q      <= step_t'(cur_step + 3'd1);
				if (cur_step == STEP_CRC_HI) begin
					crc_q <= CRC_INIT;
				end else if (cur_step != STEP_CRC_LO) begin
					crc_q <= crc_fold(crc_base, cur_byte);
				end
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_byte_q   <= cur_byte;
			frame_last_q <= (cur_step == STEP_CRC_HI);
		end
	end

	assign out_valid  = out_valid_q;
	assign out_byte   = out_byte_q;
	assign frame_last = frame_last_q;

	a_busy_has_job: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> !empty)
		else $error("sequencer mid-job with empty queue");

	a_busy_step: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (step_q != STEP_HEADER) && (step_q <= STEP_CRC_HI))
		else $error("sequencer step out of range");

	a_crc_reinit: assert property (@(posedge clk) disable iff (!arst_n)
		emit && (cur_step == STEP_CRC_HI) |=> crc_q == CRC_INIT && frame_last_q)
		else $error("CRC not reinitialized after frame close");

endmodule

// File: rtl/rs485_frame_builder_crc16_top.sv
// A start or in-frame payload item is queued as a job; the back-end sequencer moves
// its bytes into the output register, one byte per cycle unless the queue is empty or
// out_* stalls. Bytes: payload 1, closing payload 3, start 5 (7 with zero length).
// The job queue (QUEUE_DEPTH entries) lets input and output stall independently.
// Reset: header_byte = 0x3E, no frame open, CRC = 0xFFFF, queue and output empty.
// ----------------------------------------------------------------------------
// rs485_frame_builder_crc16_top - request frame builder with Modbus CRC-16
// Front end classifies transactions, a job queue decouples it from the byte
// sequencer that emits header, payload and CRC bytes.
// ----------------------------------------------------------------------------
module rs485_frame_builder_crc16_top import rfb_pkg::*; #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [7:0] cfg_wdata,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       cmd,
	input  logic [7:0] packet_seq,
	input  logic [7:0] device_addr,
	input  logic [7:0] command_code,
	input  logic [7:0] payload_len,
	input  logic [7:0] data_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       frame_last
);

	logic [7:0] header_byte_q;
	logic       push;
	job_t       push_job;
	logic       full;
	logic       pop;
	job_t       head_job;
	logic       empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_byte_q <= HEADER_INIT;
		end else if (cfg_we) begin
			header_byte_q <= cfg_wdata;
		end
	end

	rfb_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.cmd          (cmd),
		.packet_seq   (packet_seq),
		.device_addr  (device_addr),
		.command_code (command_code),
		.payload_len  (payload_len),
		.data_byte    (data_byte),
		.push         (push),
		.push_job     (push_job),
		.full         (full)
	);

	rfb_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.full     (full),
		.pop      (pop),
		.head_job (head_job),
		.empty    (empty)
	);

	rfb_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.header_byte (header_byte_q),
		.head_job    (head_job),
		.empty       (empty),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_byte    (out_byte),
		.frame_last  (frame_last)
	);

endmodule

// File: sim/rfb_frame_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rfb_frame_checker - scoreboard for the request frame builder
// Watches the input, output and register ports, predicts every frame byte
// with its own Modbus CRC-16 model and compares each output transaction with
// the oldest predicted byte.
// ----------------------------------------------------------------------------
module rfb_frame_checker import rfb_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [7:0] cfg_wdata,
	input  logic       in_valid,
	input  logic       in_ready,
	input  logic       cmd,
	input  logic [7:0] packet_seq,
	input  logic [7:0] device_addr,
	input  logic [7:0] command_code,
	input  logic [7:0] payload_len,
	input  logic [7:0] data_byte,
	input  logic       out_valid,
	input  logic       out_ready,
	input  logic [7:0] out_byte,
	input  logic       frame_last,
	output int         fail_count,
	output int         bytes_due
);

	typedef struct packed {
		logic [7:0] octet;
		logic       last;
	} frame_octet_t;

	frame_octet_t octets_due[$];
	frame_octet_t oldest;

	logic [7:0]  hdr_val;
	logic [15:0] crc_run;
	logic [7:0]  payload_left;
	logic        frame_active;

	// bit-serial form of the reflected CRC, LSB of the data first
	function automatic logic [15:0] crc16_update(input logic [15:0] acc, input logic [7:0] d);
		logic [15:0] r;
		logic        fb;
		r = acc;
		for (int k = 0; k < 8; k++) begin
			fb = r[0] ^ d[k];
			r = r >> 1;
			if (fb) begin
				r = r ^ CRC_POLY;
			end
		end
		return r;
	endfunction

	task automatic push_octet(input logic [7:0] v, input logic last);
		frame_octet_t o;
		o.octet = v;
		o.last = last;
		octets_due.push_back(o);
	endtask

	task automatic emit_folded(input logic [7:0] v);
		push_octet(v, 1'b0);
		crc_run = crc16_update(crc_run, v);
	endtask

	task automatic close_frame();
		push_octet(crc_run[7:0], 1'b0);
		push_octet(crc_run[15:8], 1'b1);
		crc_run = CRC_INIT;
		payload_left = 8'd0;
		frame_active = 1'b0;
	endtask

	task automatic predict_frame_bytes(input logic c, input logic [7:0] pno,
			input logic [7:0] addr, input logic [7:0] code, input logic [7:0] len,
			input logic [7:0] d);
		if (c == CMD_START) begin
			// a start always restarts the CRC, abandoning any open frame
			crc_run = CRC_INIT;
			emit_folded(hdr_val);
			emit_folded(pno);
			emit_folded(addr);
			emit_folded(code);
			emit_folded(len);
			if (len == 8'd0) begin
				close_frame();
			end else begin
				payload_left = len;
				frame_active = 1'b1;
			end
		end else if (frame_active) begin
			emit_folded(d);
			payload_left = payload_left - 8'd1;
			if (payload_left == 8'd0) begin
				close_frame();
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_val = HEADER_INIT;
			crc_run = CRC_INIT;
			payload_left = 8'd0;
			frame_active = 1'b0;
			octets_due.delete();
			fail_count = 0;
			bytes_due = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (octets_due.size() == 0) begin
					$error("unexpected transaction: out_byte %02h frame_last %0b",
						out_byte, frame_last);
					fail_count++;
				end else begin
					oldest = octets_due.pop_front();
					if (out_byte !== oldest.octet) begin
						$error("out_byte: expected %02h, actual %02h", oldest.octet, out_byte);
						fail_count++;
					end
					if (frame_last !== oldest.last) begin
						$error("frame_last: expected %0b, actual %0b", oldest.last, frame_last);
						fail_count++;
					end
				end
			end
			if (cfg_we) begin
				hdr_val = cfg_wdata;
			end
			if (in_valid && in_ready) begin
				predict_frame_bytes(cmd, packet_seq, device_addr, command_code, payload_len,
					data_byte);
			end
			bytes_due = octets_due.size();
		end
	end

endmodule

// File: sim/rs485_frame_builder_crc16_top_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rs485_frame_builder_crc16_top_test - testbench for the request frame builder
// Drives directed and random frames (zero length, maximum length, abandoned
// frames, stray payload bytes) under random idling and back-pressure, changes
// the header register between phases and reports the scoreboard verdict.
// ----------------------------------------------------------------------------
module rs485_frame_builder_crc16_top_test import rfb_pkg::*;;

	localparam int CYCLE_LIMIT   = 400000;
	localparam int SETTLE_CYCLES = 20;
	localparam int HOLD_CYCLES   = 400;

	logic       clk;
	logic       arst_n;
	logic       cfg_we;
	logic [7:0] cfg_wdata;
	logic       in_valid;
	logic       in_ready;
	logic       cmd;
	logic [7:0] packet_seq;
	logic [7:0] device_addr;
	logic [7:0] command_code;
	logic [7:0] payload_len;
	logic [7:0] data_byte;
	logic       out_valid;
	logic       out_ready;
	logic [7:0] out_byte;
	logic       frame_last;

	int fail_count;
	int bytes_due;
	int cycle_cnt = 0;
	bit steady_in = 1'b0;
	bit steady_out = 1'b0;
	bit rx_hold = 1'b0;

	rs485_frame_builder_crc16_top uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.cmd          (cmd),
		.packet_seq   (packet_seq),
		.device_addr  (device_addr),
		.command_code (command_code),
		.payload_len  (payload_len),
		.data_byte    (data_byte),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_byte     (out_byte),
		.frame_last   (frame_last)
	);

	rfb_frame_checker frame_chk (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.cmd          (cmd),
		.packet_seq   (packet_seq),
		.device_addr  (device_addr),
		.command_code (command_code),
		.payload_len  (payload_len),
		.data_byte    (data_byte),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_byte     (out_byte),
		.frame_last   (frame_last),
		.fail_count   (fail_count),
		.bytes_due    (bytes_due)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("rs485_frame_builder_crc16_top: mismatch");
			$finish;
		end
	end

	// receiver: random stall per transaction, one long hold-off on request
	initial begin
		int stall;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (rx_hold) begin
				stall = HOLD_CYCLES;
				rx_hold = 1'b0;
			end else begin
				stall = steady_out ? 0 : $urandom_range(0, 14);
			end
			if (stall > 0) begin
				out_ready = 1'b0;
				repeat (stall) @(negedge clk);
			end
			out_ready = 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	task automatic send_item(input logic c, input logic [7:0] pno, input logic [7:0] addr,
			input logic [7:0] code, input logic [7:0] len, input logic [7:0] d);
		int gap;
		gap = steady_in ? 0 : $urandom_range(0, 14);
		@(negedge clk);
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		cmd = c;
		packet_seq = pno;
		device_addr = addr;
		command_code = code;
		payload_len = len;
		data_byte = d;
		in_valid = 1'b1;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic send_payload_byte();
		send_item(CMD_PAYLOAD, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
			8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
			8'($urandom_range(0, 255)));
	endtask

	// start plus body payload bytes; a short body leaves the frame open
	task automatic frame_items(input int len, input int body);
		send_item(CMD_START, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
			8'($urandom_range(0, 255)), len[7:0], 8'($urandom_range(0, 255)));
		repeat (body) send_payload_byte();
	endtask

	task automatic run_random(input int target);
		int n;
		int len;
		int body;
		int pick;
		n = 0;
		while (n < target) begin
			pick = $urandom_range(0, 99);
			if (pick < 30) begin
				len = 0;
			end else if (pick < 75) begin
				len = $urandom_range(1, 4);
			end else begin
				len = $urandom_range(5, 16);
			end
			body = len;
			if (len > 1 && $urandom_range(0, 9) == 0) begin
				body = $urandom_range(0, len - 1);
			end
			frame_items(len, body);
			n += body + 1;
			// stray byte with no frame open
			if (body == len && $urandom_range(0, 5) == 0) begin
				send_payload_byte();
			end
		end
	endtask

	// hold input idle until every predicted byte has left, then let the queue settle
	task automatic wait_frames_out();
		@(negedge clk);
		in_valid = 1'b0;
		while (bytes_due != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic set_header(input logic [7:0] v);
		wait_frames_out();
		cfg_we = 1'b1;
		cfg_wdata = v;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	initial begin
		logic [7:0] hdr_extremes [2];
		hdr_extremes[0] = 8'hFF;
		hdr_extremes[1] = 8'h00;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = 8'h00;
		in_valid = 1'b0;
		cmd = CMD_START;
		packet_seq = 8'h00;
		device_addr = 8'h00;
		command_code = 8'h00;
		payload_len = 8'h00;
		data_byte = 8'h00;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;

		// directed part with the reset header
		send_item(CMD_START, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
		send_item(CMD_PAYLOAD, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
		send_item(CMD_START, 8'hFF, 8'hFF, 8'hFF, 8'h01, 8'h00);
		send_item(CMD_PAYLOAD, 8'h00, 8'h00, 8'h00, 8'h00, 8'hFF);
		send_item(CMD_START, 8'h01, 8'h02, 8'h03, 8'h03, 8'hAA);
		send_item(CMD_PAYLOAD, 8'h55, 8'h55, 8'h55, 8'h55, 8'h00);
		// abandon the open frame
		send_item(CMD_START, 8'h80, 8'h7F, 8'h55, 8'h02, 8'hC3);
		send_item(CMD_PAYLOAD, 8'h00, 8'h00, 8'h00, 8'h00, 8'hA5);
		send_item(CMD_PAYLOAD, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h5A);
		send_item(CMD_START, 8'hFE, 8'h01, 8'hC3, 8'hFF, 8'h00);
		send_item(CMD_PAYLOAD, 8'h00, 8'h00, 8'h00, 8'h00, 8'h3C);
		send_item(CMD_PAYLOAD, 8'h00, 8'h00, 8'h00, 8'h00, 8'hC3);
		send_item(CMD_START, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'hFF);
		send_item(CMD_PAYLOAD, 8'h00, 8'h00, 8'h00, 8'h00, 8'h81);

		foreach (hdr_extremes[i]) begin
			set_header(hdr_extremes[i]);
			frame_items(0, 0);
			frame_items(1, 1);
		end

		// random frames, normal idling
		set_header(8'($urandom_range(0, 255)));
		run_random(90);

		// no idling on either side
		set_header(8'($urandom_range(0, 255)));
		steady_in = 1'b1;
		steady_out = 1'b1;
		run_random(60);
		steady_in = 1'b0;
		steady_out = 1'b0;

		// long receiver hold-off while the sender keeps offering
		wait_frames_out();
		rx_hold = 1'b1;
		steady_in = 1'b1;
		run_random(30);
		steady_in = 1'b0;
		wait_frames_out();
		run_random(50);

		// one full maximum-length frame
		set_header(8'($urandom_range(0, 255)));
		frame_items(255, 255);
		run_random(20);

		wait_frames_out();
		if (fail_count == 0) begin
			$display("rs485_frame_builder_crc16_top: match");
		end else begin
			$display("rs485_frame_builder_crc16_top: mismatch");
		end
		$finish;
	end

endmodule
